// ===== hdl/lgf_pkg.sv =====
// Package for the gap fill block: patch geometry, function codes and
// register indexes with their reset values. No dependencies.
package lgf_pkg;
  localparam int PATCH_N = 32;
  localparam int CRD_W = 5;
  localparam int ADDR_W = 2 * CRD_W;
  localparam int CELLS = PATCH_N * PATCH_N;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] REG_NO_DATA = 2'd0;
  localparam logic [1:0] REG_BAD_DATA = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [7:0] NO_DATA_RST = 8'd224;
  localparam logic [7:0] BAD_DATA_RST = 8'd166;
  localparam logic [5:0] MAX_ITER_RST = 6'd15;
  localparam logic [15:0] THRESH_RST = 16'd128;

  localparam logic [CRD_W-1:0] LAST_CRD = CRD_W'(PATCH_N - 1);
  localparam logic [CRD_W-1:0] LAST_INNER = CRD_W'(PATCH_N - 2);
endpackage

// ===== hdl/lgf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module lgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/laplace_gap_fill_top.sv =====
// Gap fill top level: pixel store, two ping-pong Q8.8 work memories and the
// run sequencer. Depends on lgf_pkg and lgf_ram.
// Write, read and run requests are taken one at a time.
// Run: check/seed pass over all pixels, then interior sweeps
// (five single-port reads per pixel), then a final pass.
// Synchronous active-low reset clears control, status and config registers;
// the memories are not cleared.
module laplace_gap_fill_top
  import lgf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_col,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel_out,
  output logic        out_status,
  output logic [5:0]  out_sweeps_used,
  output logic [15:0] out_peak_change,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_SEED = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_SWEND = 3'd4;
  localparam logic [2:0] ST_FIN = 3'd5;

  logic [2:0] state_r;
  logic [2:0] sp_r;
  logic [CRD_W-1:0] r_r, c_r;
  logic sel_r;
  logic [7:0] nd_r, bd_r;
  logic [5:0] maxit_r, sweeps_r;
  logic [15:0] thr_r, peak_r;
  logic status_r;
  logic out_valid_r;
  logic [7:0] pix_out_r;
  logic [15:0] d0_r, d1_r, d2_r, d3_r;

  logic accept;
  logic out_set;
  logic [ADDR_W-1:0] raw_raddr, raw_waddr, wk_raddr, k_addr;
  logic [7:0] raw_rdata, raw_wdata;
  logic raw_we;
  logic [15:0] a_rdata, b_rdata, wk_rdata, wk_wdata;
  logic a_we, b_we;
  logic [15:0] rd16;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_pixel_out = pix_out_r;
  assign out_status = status_r;
  assign out_sweeps_used = sweeps_r;
  assign out_peak_change = peak_r;
  assign k_addr = {r_r, c_r};
  assign wk_rdata = sel_r ? b_rdata : a_rdata;
  assign rd16 = (state_r == ST_SEED) ? {8'd0, raw_rdata} : wk_rdata;

  function automatic logic flagged(input logic [7:0] v, input logic [7:0] nd,
                                   input logic [7:0] bd);
    return (v == nd) || (v == bd);
  endfunction

  // seed computation
  logic [7:0] px, lv, rv, tv, bv;
  logic pmiss, pfail;
  logic signed [17:0] seed_sum;
  logic [15:0] seed_val;
  always_comb begin
    px = d0_r[7:0];
    lv = d1_r[7:0];
    rv = d2_r[7:0];
    tv = d3_r[7:0];
    bv = raw_rdata;
    pmiss = flagged(px, nd_r, bd_r) || (px == 8'd0);
    pfail = pmiss && (flagged(lv, nd_r, bd_r) || flagged(rv, nd_r, bd_r) ||
                      flagged(tv, nd_r, bd_r) || flagged(bv, nd_r, bd_r));
    seed_sum = 18'(signed'({10'd0, lv}) * 18'(PATCH_N))
             + 18'(signed'({13'd0, c_r}) * (signed'({10'd0, rv}) - signed'({10'd0, lv})))
             + 18'(signed'({10'd0, tv}) * 18'(PATCH_N))
             + 18'(signed'({13'd0, r_r}) * (signed'({10'd0, bv}) - signed'({10'd0, tv})));
    seed_val = pmiss ? 16'((({14'd0, seed_sum} << 8) + 32'(PATCH_N)) / (2 * PATCH_N))
                     : {px, 8'd0};
  end

  // relaxation step
  logic [17:0] nb_sum;
  logic [15:0] nv, dv;
  always_comb begin
    nb_sum = {2'd0, d1_r} + {2'd0, d2_r} + {2'd0, d3_r} + {2'd0, wk_rdata};
    nv = 16'((nb_sum + 18'd2) >> 2);
    dv = (nv > d0_r) ? nv - d0_r : d0_r - nv;
  end

  // final write-back
  logic [16:0] rnd;
  logic rmiss;
  always_comb begin
    rnd = ({1'b0, wk_rdata} + 17'd128) >> 8;
    rmiss = flagged(raw_rdata, nd_r, bd_r) || (raw_rdata == 8'd0);
  end

  // raise the result valid when a request completes
  always_comb begin
    case (state_r)
      ST_IDLE: out_set = accept && (in_func != FUNC_READ) && (in_func != FUNC_RUN);
      ST_READ: out_set = 1'b1;
      ST_SEED: out_set = (sp_r == 3'd5) && pfail;
      ST_FIN: out_set = (sp_r == 3'd1) && (c_r == LAST_CRD) && (r_r == LAST_CRD);
      default: out_set = 1'b0;
    endcase
  end

  // read addresses by step
  always_comb begin
    raw_raddr = {in_row, in_col};
    wk_raddr = k_addr;
    if (state_r == ST_SEED) begin
      case (sp_r)
        3'd1: raw_raddr = {r_r, {CRD_W{1'b0}}};
        3'd2: raw_raddr = {r_r, LAST_CRD};
        3'd3: raw_raddr = {{CRD_W{1'b0}}, c_r};
        3'd4: raw_raddr = {LAST_CRD, c_r};
        default: raw_raddr = k_addr;
      endcase
    end else if (state_r == ST_FIN) begin
      raw_raddr = k_addr;
    end
    case (sp_r)
      3'd1: wk_raddr = {r_r, c_r - 1'b1};
      3'd2: wk_raddr = {r_r, c_r + 1'b1};
      3'd3: wk_raddr = {r_r - 1'b1, c_r};
      3'd4: wk_raddr = {r_r + 1'b1, c_r};
      default: wk_raddr = k_addr;
    endcase
  end

  // write ports
  always_comb begin
    raw_we = 1'b0;
    raw_waddr = {in_row, in_col};
    raw_wdata = in_pixel_in;
    a_we = 1'b0;
    b_we = 1'b0;
    wk_wdata = seed_val;
    case (state_r)
      ST_IDLE: raw_we = accept && (in_func == FUNC_WRITE);
      ST_SEED: begin
        a_we = (sp_r == 3'd5) && !pfail;
        b_we = a_we;
      end
      ST_SWEEP: begin
        wk_wdata = nv;
        a_we = (sp_r == 3'd5) && sel_r;
        b_we = (sp_r == 3'd5) && !sel_r;
      end
      ST_FIN: begin
        raw_waddr = k_addr;
        raw_wdata = (rnd > 17'd255) ? 8'd255 : rnd[7:0];
        raw_we = (sp_r == 3'd1) && rmiss;
      end
      default: raw_we = 1'b0;
    endcase
  end

  lgf_ram #(.WIDTH(8), .DEPTH(CELLS)) u_raw (
    .clk(clk), .we(raw_we), .waddr(raw_waddr), .wdata(raw_wdata),
    .raddr(raw_raddr), .rdata(raw_rdata));
  lgf_ram #(.WIDTH(16), .DEPTH(CELLS)) u_wka (
    .clk(clk), .we(a_we), .waddr(k_addr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(a_rdata));
  lgf_ram #(.WIDTH(16), .DEPTH(CELLS)) u_wkb (
    .clk(clk), .we(b_we), .waddr(k_addr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(b_rdata));

  logic [5:0] sw_inc, cap;
  assign sw_inc = sweeps_r + 6'd1;
  assign cap = (maxit_r == 6'd0) ? 6'd1 : maxit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r <= 3'd0;
      out_valid_r <= 1'b0;
      nd_r <= NO_DATA_RST;
      bd_r <= BAD_DATA_RST;
      maxit_r <= MAX_ITER_RST;
      thr_r <= THRESH_RST;
      sweeps_r <= 6'd0;
      peak_r <= 16'd0;
      status_r <= 1'b0;
      sel_r <= 1'b0;
      r_r <= '0;
      c_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NO_DATA: nd_r <= cfg_data[7:0];
          REG_BAD_DATA: bd_r <= cfg_data[7:0];
          REG_MAX_ITER: maxit_r <= cfg_data[5:0];
          REG_THRESH: thr_r <= cfg_data;
          default: nd_r <= nd_r;
        endcase
      end
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // capture read data of the previous step
      case (sp_r)
        3'd1: d0_r <= rd16;
        3'd2: d1_r <= rd16;
        3'd3: d2_r <= rd16;
        3'd4: d3_r <= rd16;
        default: d0_r <= d0_r;
      endcase
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            pix_out_r <= 8'd0;
            case (in_func)
              FUNC_READ: state_r <= ST_READ;
              FUNC_RUN: begin
                state_r <= ST_SEED;
                sp_r <= 3'd0;
                r_r <= '0;
                c_r <= '0;
              end
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          pix_out_r <= raw_rdata;
          state_r <= ST_IDLE;
        end
        ST_SEED: begin
          if (sp_r != 3'd5) begin
            sp_r <= sp_r + 3'd1;
          end else begin
            sp_r <= 3'd0;
            if (pfail) begin
              status_r <= 1'b1;
              sweeps_r <= 6'd0;
              peak_r <= 16'd0;
              state_r <= ST_IDLE;
            end else if (c_r != LAST_CRD) begin
              c_r <= c_r + 1'b1;
            end else if (r_r != LAST_CRD) begin
              c_r <= '0;
              r_r <= r_r + 1'b1;
            end else begin
              // start sweeping at the first interior pixel
              state_r <= ST_SWEEP;
              r_r <= CRD_W'(1);
              c_r <= CRD_W'(1);
              sel_r <= 1'b0;
              sweeps_r <= 6'd0;
              peak_r <= 16'd0;
            end
          end
        end
        ST_SWEEP: begin
          if (sp_r != 3'd5) begin
            sp_r <= sp_r + 3'd1;
          end else begin
            sp_r <= 3'd0;
            if (dv > peak_r) begin
              peak_r <= dv;
            end
            if (c_r != LAST_INNER) begin
              c_r <= c_r + 1'b1;
            end else if (r_r != LAST_INNER) begin
              c_r <= CRD_W'(1);
              r_r <= r_r + 1'b1;
            end else begin
              c_r <= CRD_W'(1);
              r_r <= CRD_W'(1);
              state_r <= ST_SWEND;
            end
          end
        end
        ST_SWEND: begin
          sweeps_r <= sw_inc;
          sel_r <= !sel_r;
          if (peak_r <= thr_r || sw_inc >= cap) begin
            state_r <= ST_FIN;
            r_r <= '0;
            c_r <= '0;
          end else begin
            peak_r <= 16'd0;
            state_r <= ST_SWEEP;
          end
        end
        ST_FIN: begin
          sp_r <= (sp_r == 3'd1) ? 3'd0 : 3'd1;
          if (sp_r == 3'd1) begin
            if (c_r != LAST_CRD) begin
              c_r <= c_r + 1'b1;
            end else begin
              c_r <= '0;
              r_r <= r_r + 1'b1;
              if (r_r == LAST_CRD) begin
                status_r <= 1'b0;
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== test/laplace_gap_fill_top_tb.sv =====
// Testbench for laplace_gap_fill_top: pixel writes, reads and fill runs checked
// against a behavioral fill predictor, with random request gaps and output stalls.
// Depends on lgf_pkg and the block's RTL.
`timescale 1ns / 1ps

module laplace_gap_fill_top_tb
  import lgf_pkg::*;
();

  localparam int WATCH_LIMIT = 1500000;
  localparam logic [1:0] FUNC_NOP = 2'd3;

  typedef struct packed {
    logic [7:0]  pixel;
    logic        status;
    logic [5:0]  sweeps;
    logic [15:0] peak;
  } fill_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [4:0]  in_row;
  logic [4:0]  in_col;
  logic [7:0]  in_pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_pixel_out;
  logic        out_status;
  logic [5:0]  out_sweeps_used;
  logic [15:0] out_peak_change;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  laplace_gap_fill_top dut (.*);

  // predictor state
  logic [7:0]  raw_px [CELLS];
  logic [15:0] work_px [CELLS];
  logic [15:0] next_px [CELLS];
  bit          gap_px [CELLS];
  logic [7:0]  no_data_code, bad_data_code;
  logic [5:0]  max_iter;
  logic [15:0] stop_thresh;
  logic        last_status;
  logic [5:0]  last_sweeps;
  logic [15:0] last_peak;

  fill_result_t pending_results[$];
  int  fail_count;
  int  idle_cycles;
  int  burst_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit is_flagged(logic [7:0] v);
    return v == no_data_code || v == bad_data_code;
  endfunction

  function automatic void run_fill();
    int n, k, r, c, lft, rgt, top, bot, sum, sweeps, peak, s, nv, ov, d, v;
    n = PATCH_N;
    for (k = 0; k < CELLS; k++) begin
      r = k / n;
      c = k % n;
      gap_px[k] = is_flagged(raw_px[k]) || raw_px[k] == 8'd0;
      if (gap_px[k] && (is_flagged(raw_px[r * n]) || is_flagged(raw_px[r * n + n - 1]) ||
                        is_flagged(raw_px[c]) || is_flagged(raw_px[(n - 1) * n + c]))) begin
        last_status = 1'b1;
        last_sweeps = '0;
        last_peak = '0;
        return;
      end
    end
    for (k = 0; k < CELLS; k++) begin
      r = k / n;
      c = k % n;
      if (gap_px[k]) begin
        lft = raw_px[r * n];
        rgt = raw_px[r * n + n - 1];
        top = raw_px[c];
        bot = raw_px[(n - 1) * n + c];
        sum = lft * n + c * (rgt - lft) + top * n + r * (bot - top);
        work_px[k] = 16'((sum * 256 + n) / (2 * n));
      end else begin
        work_px[k] = {raw_px[k], 8'd0};
      end
    end
    sweeps = 0;
    do begin
      peak = 0;
      sweeps++;
      for (r = 1; r < n - 1; r++)
        for (c = 1; c < n - 1; c++) begin
          k = r * n + c;
          s = work_px[k - 1] + work_px[k + 1] + work_px[k - n] + work_px[k + n];
          nv = (s + 2) >> 2;
          ov = work_px[k];
          d = nv > ov ? nv - ov : ov - nv;
          next_px[k] = 16'(nv);
          if (d > peak) peak = d;
        end
      for (r = 1; r < n - 1; r++)
        for (c = 1; c < n - 1; c++)
          work_px[r * n + c] = next_px[r * n + c];
    end while (peak > stop_thresh && sweeps < max_iter);
    for (k = 0; k < CELLS; k++)
      if (gap_px[k]) begin
        v = (work_px[k] + 128) >> 8;
        raw_px[k] = v > 255 ? 8'd255 : 8'(v);
      end
    last_status = 1'b0;
    last_sweeps = 6'(sweeps);
    last_peak = 16'(peak);
  endfunction

  function automatic fill_result_t predict_request(logic [1:0] f, logic [4:0] r,
                                                   logic [4:0] c, logic [7:0] p);
    fill_result_t res;
    int k;
    k = r * PATCH_N + c;
    res.pixel = '0;
    case (f)
      FUNC_WRITE: raw_px[k] = p;
      FUNC_RUN:   run_fill();
      FUNC_READ:  res.pixel = raw_px[k];
      default: ;
    endcase
    res.status = last_status;
    res.sweeps = last_sweeps;
    res.peak = last_peak;
    return res;
  endfunction

  // one request, with burst/gap pacing afterwards
  task automatic send_req(logic [1:0] f, logic [4:0] r, logic [4:0] c, logic [7:0] p);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_func = f;
    in_row = r;
    in_col = c;
    in_pixel_in = p;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pending_results.push_back(predict_request(f, r, c, p));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      REG_NO_DATA:  no_data_code = val[7:0];
      REG_BAD_DATA: bad_data_code = val[7:0];
      REG_MAX_ITER: max_iter = val[5:0];
      default:      stop_thresh = val;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [7:0] good_px();
    logic [7:0] v;
    do v = 8'($urandom); while (is_flagged(v));
    return v;
  endfunction

  function automatic logic [7:0] gap_code();
    case ($urandom_range(0, 2))
      0: return no_data_code;
      1: return bad_data_code;
      default: return 8'd0;
    endcase
  endfunction

  // boundary kept clean, interior partly missing
  task automatic load_patch(int miss_pct);
    int r, c;
    logic [7:0] v;
    for (r = 0; r < PATCH_N; r++)
      for (c = 0; c < PATCH_N; c++) begin
        if (r == 0 || c == 0 || r == PATCH_N - 1 || c == PATCH_N - 1)
          v = good_px();
        else if ($urandom_range(0, 99) < miss_pct)
          v = gap_code();
        else
          v = 8'($urandom);
        send_req(FUNC_WRITE, 5'(r), 5'(c), v);
      end
  endtask

  task automatic test_reset_state();
    send_req(FUNC_NOP, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_NOP, 5'd31, 5'd31, 8'd255);
  endtask

  task automatic test_patch_load();
    load_patch(30);
    send_req(FUNC_WRITE, 5'd0, 5'd0, 8'd255);
    send_req(FUNC_WRITE, LAST_CRD, LAST_CRD, 8'd1);
    send_req(FUNC_WRITE, 5'd0, LAST_CRD, 8'd128);
    send_req(FUNC_WRITE, 5'd10, 5'd21, 8'd0);
    send_req(FUNC_READ, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_READ, LAST_CRD, LAST_CRD, 8'hff);
    send_req(FUNC_READ, 5'd10, 5'd21, 8'd0);
    send_req(FUNC_NOP, 5'd5, 5'd5, 8'd7);
  endtask

  task automatic test_default_run();
    send_req(FUNC_RUN, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_READ, 5'd10, 5'd21, 8'd0);
    send_req(FUNC_READ, 5'd16, 5'd16, 8'd0);
    send_req(FUNC_NOP, 5'd0, 5'd0, 8'd0);
  endtask

  task automatic test_boundary_fail();
    // flagged row end with a gap in that row
    send_req(FUNC_WRITE, 5'd7, 5'd0, no_data_code);
    send_req(FUNC_WRITE, 5'd7, 5'd9, 8'd0);
    send_req(FUNC_RUN, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_READ, 5'd7, 5'd9, 8'd0);
    send_req(FUNC_WRITE, 5'd7, 5'd0, 8'd50);
    // flagged column end
    send_req(FUNC_WRITE, LAST_CRD, 5'd12, bad_data_code);
    send_req(FUNC_WRITE, 5'd3, 5'd12, bad_data_code);
    send_req(FUNC_RUN, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_WRITE, LAST_CRD, 5'd12, 8'd200);
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_reg(REG_MAX_ITER, 16'd63);
    write_reg(REG_THRESH, 16'd0);
    send_req(FUNC_RUN, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_READ, 5'd3, 5'd12, 8'd0);
    wait_idle();
    write_reg(REG_MAX_ITER, 16'd0);
    write_reg(REG_THRESH, 16'hffff);
    write_reg(REG_NO_DATA, 16'd0);
    write_reg(REG_BAD_DATA, 16'd255);
    send_req(FUNC_WRITE, 5'd20, 5'd20, 8'd255);
    send_req(FUNC_RUN, 5'd0, 5'd0, 8'd0);
    send_req(FUNC_READ, 5'd20, 5'd20, 8'd0);
    wait_idle();
    write_reg(REG_MAX_ITER, 16'd1);
    write_reg(REG_NO_DATA, 16'd255);
    write_reg(REG_BAD_DATA, 16'd0);
    send_req(FUNC_RUN, 5'd0, 5'd0, 8'd0);
  endtask

  task automatic test_random_traffic();
    int seg, i, r, c, sel;
    for (seg = 0; seg < 8; seg++) begin
      wait_idle();
      write_reg(REG_NO_DATA, 16'($urandom_range(1, 255)));
      write_reg(REG_BAD_DATA, 16'($urandom_range(1, 255)));
      write_reg(REG_MAX_ITER, 16'($urandom_range(1, 6)));
      write_reg(REG_THRESH, $urandom_range(0, 3) == 0 ? 16'($urandom) :
                                                        16'($urandom_range(0, 1500)));
      for (i = 0; i < 110; i++) begin
        r = $urandom_range(0, PATCH_N - 1);
        c = $urandom_range(0, PATCH_N - 1);
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          if (r == 0 || c == 0 || r == PATCH_N - 1 || c == PATCH_N - 1)
            send_req(FUNC_WRITE, 5'(r), 5'(c),
                     $urandom_range(0, 19) == 0 ? gap_code() : good_px());
          else
            send_req(FUNC_WRITE, 5'(r), 5'(c),
                     $urandom_range(0, 2) == 0 ? gap_code() : 8'($urandom));
        end else if (sel < 90) begin
          send_req(FUNC_READ, 5'(r), 5'(c), 8'($urandom));
        end else begin
          send_req(FUNC_NOP, 5'(r), 5'(c), 8'($urandom));
        end
      end
      send_req(FUNC_RUN, 5'($urandom), 5'($urandom), 8'($urandom));
      for (i = 0; i < 20; i++)
        send_req(FUNC_READ, 5'($urandom), 5'($urandom), 8'($urandom));
    end
  endtask

  // receiver stall pattern: quiet, light and heavy stretches
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(1, 200);
      end
      left--;
      case (mode)
        0: out_stall = 1'b0;
        1: out_stall = $urandom_range(0, 7) == 0;
        default: out_stall = $urandom_range(0, 1);
      endcase
    end
  end

  always @(posedge clk) begin
    fill_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d status=%0d sweeps=%0d peak=%0d", $time,
                 out_pixel_out, out_status, out_sweeps_used, out_peak_change);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_pixel_out !== want.pixel) begin
          $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel, out_pixel_out);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_sweeps_used !== want.sweeps) begin
          $display("%0t: sweeps_used expected %0d actual %0d", $time, want.sweeps,
                   out_sweeps_used);
          fail_count++;
        end
        if (out_peak_change !== want.peak) begin
          $display("%0t: peak_change expected %0d actual %0d", $time, want.peak,
                   out_peak_change);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_NOP;
    in_row = '0;
    in_col = '0;
    in_pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NO_DATA;
    cfg_data = '0;
    burst_left = 0;
    no_data_code = NO_DATA_RST;
    bad_data_code = BAD_DATA_RST;
    max_iter = MAX_ITER_RST;
    stop_thresh = THRESH_RST;
    last_status = 1'b0;
    last_sweeps = '0;
    last_peak = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_patch_load();
    test_default_run();
    test_boundary_fail();
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
